// ===== rtl/core/scf_pkg.sv =====
`timescale 1ns / 1ps

package scf_pkg;

    localparam int NUM_SORTS   = 16;
    localparam int SORT_BITS   = $clog2(NUM_SORTS);
    localparam int PAIR_BITS   = 2 * SORT_BITS;
    localparam int NUM_PAIRS   = NUM_SORTS * NUM_SORTS;
    localparam int TAG_BITS    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

    typedef logic [NUM_SORTS-1:0] t_row;

    typedef struct packed {
        logic load_edge;
        logic init_reach;
        logic clos_step;
        logic srch_step;
        logic tag_cap;
        logic rset_init;
        logic rset_grow;
        logic pick;
        logic advance;
        logic out_load;
        logic out_none;
        logic out_last;
        logic clear_all;
    } t_cmd;

    typedef struct packed {
        logic cnt_last;
        logic srch_hit;
        logic grow_done;
        logic walk_end;
        logic cand_none;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/scf_ctrl.sv =====
`timescale 1ns / 1ps

module scf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_edge,
    input  scf_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output scf_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_CLOS   = 4'd2;
    localparam logic [3:0] S_SRCH   = 4'd3;
    localparam logic [3:0] S_NONE   = 4'd4;
    localparam logic [3:0] S_RDT    = 4'd5;
    localparam logic [3:0] S_TAG    = 4'd6;
    localparam logic [3:0] S_CHK    = 4'd7;
    localparam logic [3:0] S_RSTART = 4'd8;
    localparam logic [3:0] S_RGROW  = 4'd9;
    localparam logic [3:0] S_PICK   = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;
    localparam logic [3:0] S_ADV    = 4'd12;
    localparam logic [3:0] S_CLEAR  = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_last;
    logic       n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_last     = r_last;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_edge = 1'b1;
                    if (i_last_edge) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_reach = 1'b1;
                n_state          = S_CLOS;
            end
            S_CLOS: begin
                o_cmd.clos_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_sts.srch_hit) begin
                    n_state = S_RDT;
                end else if (i_sts.cnt_last) begin
                    n_state = S_NONE;
                end
            end
            S_NONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_none = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_CLEAR;
                end
            end
            S_RDT: begin
                n_state = S_TAG;
            end
            S_TAG: begin
                o_cmd.tag_cap = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                if (i_sts.walk_end) begin
                    n_last  = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RSTART;
                end
            end
            S_RSTART: begin
                o_cmd.rset_init = 1'b1;
                n_state         = S_RGROW;
            end
            S_RGROW: begin
                o_cmd.rset_grow = 1'b1;
                if (i_sts.grow_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_last     = i_sts.cand_none;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = r_last;
                    n_state        = r_last ? S_CLEAR : S_ADV;
                end
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = S_RDT;
            end
            S_CLEAR: begin
                o_cmd.clear_all = 1'b1;
                n_last          = 1'b0;
                n_state         = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/core/scf_dp.sv =====
`timescale 1ns / 1ps

module scf_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scf_pkg::t_cmd                 i_cmd,
    output scf_pkg::t_sts                 o_sts,
    input  logic [scf_pkg::SORT_BITS-1:0] i_from_sort,
    input  logic [scf_pkg::SORT_BITS-1:0] i_to_sort,
    input  logic                          i_is_strict,
    input  logic [scf_pkg::TAG_BITS-1:0]  i_edge_tag,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_cycle_found,
    output logic [scf_pkg::SORT_BITS-1:0] o_out_from,
    output logic [scf_pkg::SORT_BITS-1:0] o_out_to,
    output logic [scf_pkg::TAG_BITS-1:0]  o_out_tag,
    output logic                          o_last_result
);

    function automatic logic [scf_pkg::SORT_BITS-1:0] lowest_idx(input scf_pkg::t_row v);
        logic [scf_pkg::SORT_BITS-1:0] idx;
        idx = '0;
        for (int i = scf_pkg::NUM_SORTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = scf_pkg::SORT_BITS'(i);
            end
        end
        return idx;
    endfunction

    scf_pkg::t_row r_edge   [scf_pkg::NUM_SORTS];
    scf_pkg::t_row r_strict [scf_pkg::NUM_SORTS];
    scf_pkg::t_row r_reach  [scf_pkg::NUM_SORTS];

    logic [scf_pkg::NUM_PAIRS-1:0] r_loose_v;
    logic [scf_pkg::NUM_PAIRS-1:0] r_tight_v;
    logic [scf_pkg::TAG_BITS-1:0]  loose_mem [scf_pkg::NUM_PAIRS];
    logic [scf_pkg::TAG_BITS-1:0]  tight_mem [scf_pkg::NUM_PAIRS];
    logic [scf_pkg::TAG_BITS-1:0]  r_loose_rd;
    logic [scf_pkg::TAG_BITS-1:0]  r_tight_rd;

    logic [scf_pkg::SORT_BITS-1:0] r_cnt;
    logic [scf_pkg::SORT_BITS-1:0] r_a;
    logic [scf_pkg::SORT_BITS-1:0] r_cur;
    logic [scf_pkg::SORT_BITS-1:0] r_next;
    scf_pkg::t_row                 r_visited;
    scf_pkg::t_row                 r_set;
    logic [scf_pkg::CNT_BITS-1:0]  r_n;
    logic                          r_first;
    logic [scf_pkg::SORT_BITS-1:0] r_pend_from;
    logic [scf_pkg::SORT_BITS-1:0] r_pend_to;
    logic [scf_pkg::TAG_BITS-1:0]  r_pend_tag;

    logic                          r_out_valid;
    logic                          r_out_found;
    logic [scf_pkg::SORT_BITS-1:0] r_out_from;
    logic [scf_pkg::SORT_BITS-1:0] r_out_to;
    logic [scf_pkg::TAG_BITS-1:0]  r_out_tag;
    logic                          r_out_last;

    logic [scf_pkg::PAIR_BITS-1:0] wr_addr;
    logic [scf_pkg::PAIR_BITS-1:0] pend_addr;
    logic                          in_range;
    logic                          wr_en;
    scf_pkg::t_row                 srch_col;
    scf_pkg::t_row                 hits;
    scf_pkg::t_row                 grow;
    scf_pkg::t_row                 set_next;
    scf_pkg::t_row                 cand;
    logic [scf_pkg::SORT_BITS-1:0] hit_b;
    logic                          cnt_last;

    assign wr_addr   = {i_from_sort, i_to_sort};
    assign pend_addr = {r_pend_from, r_pend_to};
    assign in_range  = ((scf_pkg::SORT_BITS + 1)'(i_from_sort)
                         < (scf_pkg::SORT_BITS + 1)'(scf_pkg::NUM_SORTS))
                    && ((scf_pkg::SORT_BITS + 1)'(i_to_sort)
                         < (scf_pkg::SORT_BITS + 1)'(scf_pkg::NUM_SORTS));
    assign wr_en     = i_cmd.load_edge && in_range;
    assign cnt_last  = (r_cnt == scf_pkg::SORT_BITS'(scf_pkg::NUM_SORTS - 1));

    always_comb begin
        for (int b = 0; b < scf_pkg::NUM_SORTS; b++) begin
            srch_col[b] = r_reach[b][r_cnt];
            grow[b]     = !r_visited[b] && (|(r_edge[b] & r_set));
        end
    end

    assign hits     = r_strict[r_cnt] & srch_col;
    assign hit_b    = lowest_idx(hits);
    assign set_next = r_set | grow;
    assign cand     = r_edge[r_cur] & r_set & ~r_visited;

    always_comb begin
        o_sts           = '0;
        o_sts.cnt_last  = cnt_last;
        o_sts.srch_hit  = |hits;
        o_sts.grow_done = (set_next == r_set);
        o_sts.walk_end  = (r_cur == r_a)
                       || (r_n == scf_pkg::CNT_BITS'(scf_pkg::MAX_RESULTS));
        o_sts.cand_none = ~|cand;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < scf_pkg::NUM_SORTS; i++) begin
                r_edge[i]   <= '0;
                r_strict[i] <= '0;
            end
            r_loose_v <= '0;
            r_tight_v <= '0;
        end else if (i_cmd.clear_all) begin
            for (int i = 0; i < scf_pkg::NUM_SORTS; i++) begin
                r_edge[i]   <= '0;
                r_strict[i] <= '0;
            end
            r_loose_v <= '0;
            r_tight_v <= '0;
        end else if (wr_en) begin
            r_edge[i_from_sort][i_to_sort] <= 1'b1;
            if (i_is_strict) begin
                r_strict[i_from_sort][i_to_sort] <= 1'b1;
                r_tight_v[wr_addr]               <= 1'b1;
            end else begin
                r_loose_v[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && i_is_strict && !r_tight_v[wr_addr]) begin
            tight_mem[wr_addr] <= i_edge_tag;
        end
        if (wr_en && !i_is_strict && !r_loose_v[wr_addr]) begin
            loose_mem[wr_addr] <= i_edge_tag;
        end
        r_tight_rd <= tight_mem[pend_addr];
        r_loose_rd <= loose_mem[pend_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_reach) begin
            for (int i = 0; i < scf_pkg::NUM_SORTS; i++) begin
                r_reach[i] <= r_edge[i];
            end
        end else if (i_cmd.clos_step) begin
            for (int i = 0; i < scf_pkg::NUM_SORTS; i++) begin
                if (r_reach[i][r_cnt]) begin
                    r_reach[i] <= r_reach[i] | r_reach[r_cnt];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.init_reach) begin
            r_cnt <= '0;
        end else if (i_cmd.clos_step || i_cmd.srch_step) begin
            r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_step && (|hits)) begin
            r_a         <= r_cnt;
            r_cur       <= hit_b;
            r_visited   <= scf_pkg::t_row'(1) << hit_b;
            r_pend_from <= r_cnt;
            r_pend_to   <= hit_b;
            r_n         <= scf_pkg::CNT_BITS'(1);
            r_first     <= 1'b1;
        end else if (i_cmd.advance) begin
            r_pend_from        <= r_cur;
            r_pend_to          <= r_next;
            r_cur              <= r_next;
            r_visited[r_next]  <= 1'b1;
            r_n                <= r_n + 1'b1;
            r_first            <= 1'b0;
        end
        if (i_cmd.tag_cap) begin
            r_pend_tag <= (r_first || !r_loose_v[pend_addr]) ? r_tight_rd : r_loose_rd;
        end
        if (i_cmd.rset_init) begin
            r_set <= scf_pkg::t_row'(1) << r_a;
        end else if (i_cmd.rset_grow) begin
            r_set <= set_next;
        end
        if (i_cmd.pick) begin
            r_next <= lowest_idx(cand);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_found <= !i_cmd.out_none;
            r_out_from  <= i_cmd.out_none ? '0 : r_pend_from;
            r_out_to    <= i_cmd.out_none ? '0 : r_pend_to;
            r_out_tag   <= i_cmd.out_none ? '0 : r_pend_tag;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cycle_found = r_out_found;
    assign o_out_from    = r_out_from;
    assign o_out_to      = r_out_to;
    assign o_out_tag     = r_out_tag;
    assign o_last_result = r_out_last;

endmodule

// ===== rtl/core/strict_cycle_finder.sv =====
`timescale 1ns / 1ps
// Finds a cycle through a strict edge in a directed graph of sorts.
// The input channel (i_in_valid/o_in_ready) carries one edge per transaction:
// source and destination sort, a strict flag, a tag and a last-edge mark.
// Edges are loaded at one transaction per cycle until the last-edge mark.
// After the last edge the block stops taking input, builds the transitive
// closure and scans one source sort per cycle for a strict edge on a cycle.
// Without a strict cycle it then sends one result with cycle_found low.
// Otherwise it sends the strict edge and then each edge of the walk back to
// its source; the reachability growth loop runs before each result that does
// not end the walk; at most 16 results, the last one flagged.
// Results leave through an output register (o_out_valid/i_out_ready); a stall
// there holds the result and pauses the walk without losing anything.
// After the final result all edge stores clear together and the block
// takes edges again. Reset, synchronous and active low, empties all edge stores.

module strict_cycle_finder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [scf_pkg::SORT_BITS-1:0] i_from_sort,
    input  logic [scf_pkg::SORT_BITS-1:0] i_to_sort,
    input  logic                          i_is_strict,
    input  logic [scf_pkg::TAG_BITS-1:0]  i_edge_tag,
    input  logic                          i_last_edge,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_cycle_found,
    output logic [scf_pkg::SORT_BITS-1:0] o_out_from,
    output logic [scf_pkg::SORT_BITS-1:0] o_out_to,
    output logic [scf_pkg::TAG_BITS-1:0]  o_out_tag,
    output logic                          o_last_result
);

    scf_pkg::t_cmd cmd;
    scf_pkg::t_sts sts;

    scf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_edge (i_last_edge),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    scf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_from_sort   (i_from_sort),
        .i_to_sort     (i_to_sort),
        .i_is_strict   (i_is_strict),
        .i_edge_tag    (i_edge_tag),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_cycle_found (o_cycle_found),
        .o_out_from    (o_out_from),
        .o_out_to      (o_out_to),
        .o_out_tag     (o_out_tag),
        .o_last_result (o_last_result)
    );

`ifndef SYNTH
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_cycle_found) |-> o_last_result)
        else $error("no-cycle result without last flag");

    a_stop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_edge) |=> !o_in_ready)
        else $error("input taken during the search");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register overwritten");
`endif

endmodule
